@@ src/binary_to_decimal_ascii_unit_assert.svh @@
// Assertion macros for the binary to decimal ASCII unit.
// Both forms expect clk in scope; BDA_ASSERT also expects rst.
`ifndef BINARY_TO_DECIMAL_ASCII_UNIT_ASSERT_SVH
`define BINARY_TO_DECIMAL_ASCII_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

`define BDA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("bda assertion failed");

`define BDA_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("bda assertion failed");

`else

`define BDA_ASSERT(lbl, prop)

`define BDA_ASSERT_ALWAYS(lbl, prop)

`endif

`endif

@@ src/bda_pkg.sv @@
`default_nettype none

package bda_pkg;

  localparam int VALUE_W    = 31;
  localparam int CHAR_W     = 6;
  localparam int MAX_DIGITS = 10;
  localparam int BIT_CNT_W  = $clog2(VALUE_W);
  localparam int DCNT_W     = $clog2(MAX_DIGITS + 1);

  // ASCII '0' is 6'b110000, so a digit 0..9 maps to {2'b11, digit}
  localparam logic [1:0] CHAR_HI = 2'b11;

  typedef logic [3:0] bcd_t;

  typedef struct packed {
    logic clear;    // zero every digit
    logic dabble;   // add-3 adjust, then shift one binary bit in
    logic dshift;   // move every digit one place toward the top
  } bda_ctrl_t;

endpackage

`default_nettype wire

@@ src/binary_to_decimal_ascii_unit.sv @@
// channel   signals                         direction
// value     value_valid, value_stall, value in
// digit     digit_valid, digit_stall,       out
//           digit_char, last_digit
//
// One value is loaded, double-dabbled through the digit cells for all of
// its 31 bits, then its MAX_DIGITS digits shift out of the top cell, one
// per cycle unless digit_stall holds a digit (leading zeros skipped, not
// sent). value_stall is high from acceptance until the last
// digit sits in the output register. digit_stall only holds the emit
// phase. rst (synchronous) clears the sequencer and the output valid.
`default_nettype none

`include "binary_to_decimal_ascii_unit_assert.svh"

module binary_to_decimal_ascii_unit (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          value_valid,
  output logic                               value_stall,
  input  wire logic [bda_pkg::VALUE_W-1:0]   value,
  output logic                               digit_valid,
  input  wire logic                          digit_stall,
  output logic [bda_pkg::CHAR_W-1:0]         digit_char,
  output logic                               last_digit
);

  typedef enum logic [1:0] {
    IDLE,
    CONV,
    EMIT
  } state_t;

  state_t                           state;
  logic [bda_pkg::VALUE_W-1:0]      bin;
  logic [bda_pkg::BIT_CNT_W-1:0]    bit_cnt;
  logic [bda_pkg::DCNT_W-1:0]       remaining;
  logic                             started;

  bda_pkg::bda_ctrl_t ctrl;
  bda_pkg::bcd_t      top_digit;
  logic               accept;
  logic               last_pos;
  logic               skip;
  logic               can_load;
  logic               load_word;

  assign value_stall = (state != IDLE);
  assign accept      = value_valid && !value_stall;
  assign last_pos    = (remaining == bda_pkg::DCNT_W'(1));
  assign skip        = !started && (top_digit == 4'd0) && !last_pos;
  assign can_load    = !digit_valid || !digit_stall;
  assign load_word   = (state == EMIT) && !skip && can_load;

  always_comb begin
    ctrl.clear  = accept;
    ctrl.dabble = (state == CONV);
    ctrl.dshift = (state == EMIT) && (skip || can_load);
  end

  bda_chain u_chain (
    .clk      (clk),
    .ctrl     (ctrl),
    .bin_bit  (bin[bda_pkg::VALUE_W-1]),
    .top_digit(top_digit)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= IDLE;
      digit_valid <= 1'b0;
    end else begin
      if (digit_valid && !digit_stall && !load_word) begin
        digit_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (accept) begin
            state   <= CONV;
            bin     <= value;
            bit_cnt <= '0;
          end
        end
        CONV: begin
          bin     <= {bin[bda_pkg::VALUE_W-2:0], 1'b0};
          bit_cnt <= bit_cnt + 1'b1;
          if (bit_cnt == bda_pkg::BIT_CNT_W'(bda_pkg::VALUE_W - 1)) begin
            state     <= EMIT;
            remaining <= bda_pkg::DCNT_W'(bda_pkg::MAX_DIGITS);
            started   <= 1'b0;
          end
        end
        EMIT: begin
          if (skip) begin
            remaining <= remaining - 1'b1;
          end else if (load_word) begin
            digit_valid <= 1'b1;
            digit_char  <= {bda_pkg::CHAR_HI, top_digit};
            last_digit  <= last_pos;
            started     <= 1'b1;
            remaining   <= remaining - 1'b1;
            if (last_pos) begin
              state <= IDLE;
            end
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  `BDA_ASSERT(a_accept_starts_conv, accept |=> (state == CONV) && (bit_cnt == '0))
  `BDA_ASSERT(a_emit_has_digits, (state == EMIT) |-> (remaining != '0))
  `BDA_ASSERT(a_char_is_digit, digit_valid |-> (digit_char >= 6'd48) && (digit_char <= 6'd57))
  `BDA_ASSERT_ALWAYS(a_reset_clears, rst |=> (state == IDLE) && !digit_valid)

endmodule

`default_nettype wire

@@ src/bda_cell.sv @@
`default_nettype none

module bda_cell (
  input  wire logic              clk,
  input  wire bda_pkg::bda_ctrl_t ctrl,
  input  wire logic              carry_in,
  input  wire bda_pkg::bcd_t     digit_in,
  output logic                   carry_out,
  output bda_pkg::bcd_t          digit
);

  bda_pkg::bcd_t adj;

  always_comb begin
    adj = (digit >= 4'd5) ? digit + 4'd3 : digit;
  end

  assign carry_out = adj[3];

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      digit <= '0;
    end else if (ctrl.dabble) begin
      digit <= {adj[2:0], carry_in};
    end else if (ctrl.dshift) begin
      digit <= digit_in;
    end
  end

endmodule

`default_nettype wire

@@ src/bda_chain.sv @@
`default_nettype none

module bda_chain (
  input  wire logic               clk,
  input  wire bda_pkg::bda_ctrl_t ctrl,
  input  wire logic               bin_bit,
  output bda_pkg::bcd_t           top_digit
);

  localparam int N = bda_pkg::MAX_DIGITS;

  logic          cy [N];
  bda_pkg::bcd_t dg [N];

  assign cy[0] = bin_bit;

  // cell 0 is the least significant digit; the carry off the top cell is
  // dropped, which leaves the value modulo 10^N
  for (genvar i = 0; i < N; i++) begin : g_cell
    if (i == N - 1) begin : g_top
      bda_cell u_cell (
        .clk      (clk),
        .ctrl     (ctrl),
        .carry_in (cy[i]),
        .digit_in ((i == 0) ? 4'd0 : dg[(i == 0) ? 0 : i - 1]),
        .carry_out(),
        .digit    (dg[i])
      );
    end else begin : g_mid
      bda_cell u_cell (
        .clk      (clk),
        .ctrl     (ctrl),
        .carry_in (cy[i]),
        .digit_in ((i == 0) ? 4'd0 : dg[(i == 0) ? 0 : i - 1]),
        .carry_out(cy[i + 1]),
        .digit    (dg[i])
      );
    end
  end

  assign top_digit = dg[N - 1];

endmodule

`default_nettype wire

@@ tb/decimal_digit_checker.sv @@
`timescale 1ns / 1ps

module decimal_digit_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         value_valid,
  input  logic                         value_stall,
  input  logic [bda_pkg::VALUE_W-1:0]  value,
  input  logic                         digit_valid,
  input  logic                         digit_stall,
  input  logic [bda_pkg::CHAR_W-1:0]   digit_char,
  input  logic                         last_digit,
  output int                           errors,
  output int                           pending,
  output int                           values_seen,
  output int                           digits_seen
);

  localparam int ASCII_ZERO = 48;

  typedef struct packed {
    logic [bda_pkg::CHAR_W-1:0] ch;
    logic                       last;
  } digit_word_t;

  digit_word_t expected_digits[$];

  initial begin
    errors      = 0;
    pending     = 0;
    values_seen = 0;
    digits_seen = 0;
  end

  // Split into MAX_DIGITS decimal positions (anything wider wraps), then queue
  // the characters from the top nonzero position down; zero gives one '0'.
  task automatic queue_decimal_digits(input logic [bda_pkg::VALUE_W-1:0] v);
    longint unsigned rest;
    bda_pkg::bcd_t   digs[bda_pkg::MAX_DIGITS];
    int              top_pos;
    digit_word_t     w;
    rest    = v;
    top_pos = 0;
    for (int i = 0; i < bda_pkg::MAX_DIGITS; i++) begin
      digs[i] = bda_pkg::bcd_t'(rest % 10);
      rest    = rest / 10;
      if (digs[i] != 0)
        top_pos = i;
    end
    for (int i = top_pos; i >= 0; i--) begin
      w.ch   = bda_pkg::CHAR_W'(ASCII_ZERO + int'(digs[i]));
      w.last = (i == 0);
      expected_digits.push_back(w);
    end
  endtask

  always @(posedge clk) begin
    digit_word_t want;
    if (!rst) begin
      // pop before push so a word leaving and a value arriving on one edge stay ordered
      if (digit_valid && !digit_stall) begin
        digits_seen++;
        if (expected_digits.size() == 0) begin
          errors++;
          $error("digit word with nothing expected: digit_char %0d last_digit %0b",
                 digit_char, last_digit);
        end else begin
          want = expected_digits.pop_front();
          if (digit_char !== want.ch) begin
            errors++;
            $error("digit_char expected %0d actual %0d", want.ch, digit_char);
          end
          if (last_digit !== want.last) begin
            errors++;
            $error("last_digit expected %0b actual %0b", want.last, last_digit);
          end
        end
      end
      if (value_valid && !value_stall) begin
        values_seen++;
        queue_decimal_digits(value);
      end
      pending = expected_digits.size();
    end
  end

endmodule

@@ tb/tb_binary_to_decimal_ascii_unit.sv @@
`timescale 1ns / 1ps

module tb_binary_to_decimal_ascii_unit;

  localparam int CYCLE_LIMIT = 600000;
  localparam int LONG_HOLD   = 300;
  localparam int TAIL_CYCLES = 80;
  localparam int VW          = bda_pkg::VALUE_W;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        value_valid = 1'b0;
  logic                        value_stall;
  logic [VW-1:0]               value = '0;
  logic                        digit_valid;
  logic                        digit_stall = 1'b0;
  logic [bda_pkg::CHAR_W-1:0]  digit_char;
  logic                        last_digit;

  int errors, pending, values_seen, digits_seen;
  int cycles = 0;

  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;
  bit hold_req   = 1'b0;

  logic [VW-1:0] corner_values[$] = '{
    31'd0, 31'd1, 31'd9, 31'd10, 31'd11, 31'd99, 31'd100, 31'd101, 31'd909,
    31'd999999999, 31'd1000000000, 31'd1000000001, 31'd1234567890,
    31'd2000000000, 31'd2147483647, 31'd1073741824, 31'd1431655765,
    31'd715827882, 31'd1000, 31'd100000, 31'd7, 31'd0
  };

  binary_to_decimal_ascii_unit dut (
    .clk         (clk),
    .rst         (rst),
    .value_valid (value_valid),
    .value_stall (value_stall),
    .value       (value),
    .digit_valid (digit_valid),
    .digit_stall (digit_stall),
    .digit_char  (digit_char),
    .last_digit  (last_digit)
  );

  decimal_digit_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .value_valid (value_valid),
    .value_stall (value_stall),
    .value       (value),
    .digit_valid (digit_valid),
    .digit_stall (digit_stall),
    .digit_char  (digit_char),
    .last_digit  (last_digit),
    .errors      (errors),
    .pending     (pending),
    .values_seen (values_seen),
    .digits_seen (digits_seen)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb_binary_to_decimal_ascii_unit: done, errors");
      $finish;
    end
  end

  // Receiver: random stall bursts, plus one long hold-off on request.
  initial begin
    wait (!rst);
    forever begin
      if (hold_req) begin
        digit_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        hold_req = 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
        digit_stall <= 1'b1;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end else begin
        digit_stall <= 1'b0;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  function automatic longint unsigned pow10_of(input int k);
    longint unsigned p;
    p = 1;
    repeat (k) p = p * 10;
    return p;
  endfunction

  // Valid stays high from one word to the next unless a gap is taken.
  task automatic send_value(input logic [VW-1:0] v);
    value       <= v;
    value_valid <= 1'b1;
    do @(posedge clk); while (value_stall);
    if (tx_idle_on && $urandom_range(0, 2) == 0) begin
      value_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    value_valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    @(posedge clk);
  endtask

  task automatic run_random(input int n);
    logic [VW-1:0] v;
    int            k;
    repeat (n) begin
      k = $urandom_range(0, 9);
      case ($urandom_range(0, 4))
        0, 1: v = VW'($urandom);
        2:    v = VW'($urandom >> $urandom_range(1, 31));
        3:    v = VW'(pow10_of(k) - $urandom_range(0, 1));
        default: v = VW'(pow10_of(k) * $urandom_range(1, 2) + $urandom_range(0, 2));
      endcase
      send_value(v);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (corner_values[i])
      send_value(corner_values[i]);

    run_random(150);

    // long output hold while values keep coming, so the input backs up
    hold_req = 1'b1;
    wait (digit_stall);
    run_random(6);

    // sender waits for every digit of what it has sent
    drain_results();

    run_random(150);

    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    run_random(45);

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("run: %0d values converted, %0d digit words checked", values_seen, digits_seen);
    $display("run: field extremes, random bursts, long output hold, full drain");
    if (errors == 0)
      $display("tb_binary_to_decimal_ascii_unit: done, clean");
    else
      $display("tb_binary_to_decimal_ascii_unit: done, errors");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+src
src/bda_pkg.sv
src/bda_cell.sv
src/bda_chain.sv
src/binary_to_decimal_ascii_unit.sv
tb/decimal_digit_checker.sv
tb/tb_binary_to_decimal_ascii_unit.sv
